// ===== src/dtpc_pkg.sv =====
package dtpc_pkg;

   // Pixel coordinate width and derived datapath widths
   localparam int CoordBits = 12;
   localparam int OffBits   = (CoordBits + 4 > 16) ? CoordBits + 4 : 16;
   localparam int ProdBits  = OffBits + 32;
   localparam int AccBits   = OffBits + 33;
   localparam int MagBits   = AccBits - 4;

   localparam int DispBits  = 15;
   localparam int NumBits   = 40;
   localparam int DivSteps  = 32;
   localparam int ProjStages = 4;

   localparam logic [15:0] FocalXReset   = 16'd16384;
   localparam logic [31:0] InvFocalReset = 32'd4194304;
   localparam logic [15:0] CenterXReset  = 16'd5120;
   localparam logic [15:0] CenterYReset  = 16'd3840;
   localparam logic [23:0] BaselineReset = 24'd35206;
   localparam logic [14:0] MinDispReset  = 15'd0;

   typedef enum logic [2:0] {
      CsrFocalX    = 3'd0,
      CsrInvFocalX = 3'd1,
      CsrInvFocalY = 3'd2,
      CsrCenterX   = 3'd3,
      CsrCenterY   = 3'd4,
      CsrBaseline  = 3'd5,
      CsrMinDisp   = 3'd6
   } csr_index_type;

   // Payload handed from one divider cell to the next
   typedef struct packed {
      logic                  ok;
      logic                  sat;
      logic [DispBits-1:0]   disp;
      logic [DispBits-1:0]   rem;
      logic [DivSteps-1:0]   qd;
      logic [CoordBits-1:0]  col;
      logic [CoordBits-1:0]  row;
      logic [23:0]           color;
   } div_data_type;

   // Depth side line running alongside the projection units
   typedef struct packed {
      logic        pvalid;
      logic [31:0] z;
      logic [23:0] color;
   } side_data_type;

endpackage

// ===== src/dtpc_div_cell.sv =====
module dtpc_div_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_full,
   input  dtpc_pkg::div_data_type    in_data,
   output logic                      out_full,
   output dtpc_pkg::div_data_type    out_data
);

   logic                     full_ff;
   dtpc_pkg::div_data_type   data_ff;
   dtpc_pkg::div_data_type   data_in;
   logic [dtpc_pkg::DispBits:0] trial;
   logic [dtpc_pkg::DispBits:0] diff;
   logic                     ge;

   // One restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {in_data.rem, in_data.qd[dtpc_pkg::DivSteps-1]};
      diff    = trial - {1'b0, in_data.disp};
      ge      = trial >= {1'b0, in_data.disp};
      data_in = in_data;
      data_in.rem = ge ? diff[dtpc_pkg::DispBits-1:0] : trial[dtpc_pkg::DispBits-1:0];
      data_in.qd  = {in_data.qd[dtpc_pkg::DivSteps-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= in_full;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_full = full_ff;
   assign out_data = data_ff;

endmodule

// ===== src/dtpc_project.sv =====
module dtpc_project (
   input  logic                           clock,
   input  logic [dtpc_pkg::CoordBits-1:0] coord,
   input  logic [15:0]                    center,
   input  logic [31:0]                    z,
   input  logic [31:0]                    inv,
   output logic signed [31:0]             result
);

   logic [dtpc_pkg::OffBits:0]            diff;
   logic                                  neg_in;
   logic [dtpc_pkg::OffBits-1:0]          mag_in;

   logic                                  neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [dtpc_pkg::OffBits-1:0]          mag1_ff;
   logic [31:0]                           z1_ff;
   logic [dtpc_pkg::ProdBits-1:0]         m2_ff;
   logic [63:0]                           lo3_ff;
   logic [dtpc_pkg::ProdBits-1:0]         hi3_ff;
   logic [dtpc_pkg::AccBits-1:0]          a4_ff;
   logic [dtpc_pkg::MagBits-1:0]          mag;

   // Signed Q.4 offset from the principal point, split into sign and magnitude
   always_comb begin
      diff   = {1'b0, dtpc_pkg::OffBits'({coord, 4'b0000})}
             - {1'b0, dtpc_pkg::OffBits'(center)};
      neg_in = diff[dtpc_pkg::OffBits];
      mag_in = neg_in ? dtpc_pkg::OffBits'(-diff) : diff[dtpc_pkg::OffBits-1:0];
   end

   always_ff @(posedge clock) begin
      neg1_ff <= neg_in;
      mag1_ff <= mag_in;
      z1_ff   <= z;
      neg2_ff <= neg1_ff;
      m2_ff   <= dtpc_pkg::ProdBits'(mag1_ff * z1_ff);
      neg3_ff <= neg2_ff;
      lo3_ff  <= 64'(m2_ff[31:0] * inv);
      hi3_ff  <= dtpc_pkg::ProdBits'(m2_ff[dtpc_pkg::ProdBits-1:32] * inv);
      neg4_ff <= neg3_ff;
      a4_ff   <= dtpc_pkg::AccBits'(hi3_ff) + dtpc_pkg::AccBits'(lo3_ff[63:32]);
   end

   // Truncate towards zero, clamp, then apply the sign
   always_comb begin
      mag = a4_ff[dtpc_pkg::AccBits-1:4];
      if (!neg4_ff) begin
         if (mag > dtpc_pkg::MagBits'(32'h7FFF_FFFF)) begin
            result = 32'sh7FFF_FFFF;
         end else begin
            result = signed'(mag[31:0]);
         end
      end else begin
         if (mag > dtpc_pkg::MagBits'(32'h8000_0000)) begin
            result = signed'(32'h8000_0000);
         end else begin
            result = signed'(32'd0 - mag[31:0]);
         end
      end
   end

endmodule

// ===== src/disparity_to_point_cloud_top.sv =====
// A pixel transfer reaches the edge that takes its result through these registers
// in order: input register, product register, divider set-up, 32 divider cells,
// four projection multiply stages, output register.
// Throughput: one pixel per cycle, every cycle; busy is low outside reset.
// Reset clears the pipeline occupancy and loads the register defaults;
// results have no back-pressure and are lost if not taken in their cycle.
module disparity_to_point_cloud_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [15:0]             req_disparity,
   input  logic [dtpc_pkg::CoordBits-1:0] req_column,
   input  logic [dtpc_pkg::CoordBits-1:0] req_row,
   input  logic [7:0]                     req_blue,
   input  logic [7:0]                     req_green,
   input  logic [7:0]                     req_red,
   output logic                           rsp_valid,
   output logic signed [31:0]             rsp_point_x,
   output logic signed [31:0]             rsp_point_y,
   output logic [31:0]                    rsp_point_z,
   output logic [23:0]                    rsp_color_packed,
   output logic                           rsp_point_valid,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [2:0]                     csr_index,
   input  logic [31:0]                    csr_data
);

   localparam int Steps = dtpc_pkg::DivSteps;

   // Configuration registers
   logic [15:0] focal_x_ff;
   logic [31:0] inv_focal_x_ff;
   logic [31:0] inv_focal_y_ff;
   logic [15:0] center_x_ff;
   logic [15:0] center_y_ff;
   logic [23:0] baseline_ff;
   logic [14:0] min_disp_ff;

   // Input stage
   logic                           accept;
   logic                           a_full_ff;
   logic                           a_ok_ff;
   logic [dtpc_pkg::DispBits-1:0]  a_disp_ff;
   logic [dtpc_pkg::CoordBits-1:0] a_col_ff;
   logic [dtpc_pkg::CoordBits-1:0] a_row_ff;
   logic [23:0]                    a_color_ff;
   logic                           a_ok_in;

   // Product stage
   logic                           p_full_ff;
   logic                           p_ok_ff;
   logic [dtpc_pkg::DispBits-1:0]  p_disp_ff;
   logic [dtpc_pkg::NumBits-1:0]   p_num_ff;
   logic [dtpc_pkg::CoordBits-1:0] p_col_ff;
   logic [dtpc_pkg::CoordBits-1:0] p_row_ff;
   logic [23:0]                    p_color_ff;

   // Divider set-up stage and cell chain
   logic                           b_full_ff;
   dtpc_pkg::div_data_type         b_data_ff;
   dtpc_pkg::div_data_type         b_data_in;
   logic                           chain_full [Steps+1];
   dtpc_pkg::div_data_type         chain_data [Steps+1];

   // Depth, projection and side line
   logic [31:0]                    z_sat;
   logic                           z_ok;
   dtpc_pkg::side_data_type        side_in;
   logic                           side_full_ff [dtpc_pkg::ProjStages];
   dtpc_pkg::side_data_type        side_ff [dtpc_pkg::ProjStages];
   logic signed [31:0]             proj_x;
   logic signed [31:0]             proj_y;

   // Output register
   logic                           rsp_valid_ff;
   logic                           rsp_pvalid_ff;
   logic signed [31:0]             rsp_x_ff;
   logic signed [31:0]             rsp_y_ff;
   logic [31:0]                    rsp_z_ff;
   logic [23:0]                    rsp_color_ff;
   dtpc_pkg::side_data_type        side_last;

   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff     <= dtpc_pkg::FocalXReset;
         inv_focal_x_ff <= dtpc_pkg::InvFocalReset;
         inv_focal_y_ff <= dtpc_pkg::InvFocalReset;
         center_x_ff    <= dtpc_pkg::CenterXReset;
         center_y_ff    <= dtpc_pkg::CenterYReset;
         baseline_ff    <= dtpc_pkg::BaselineReset;
         min_disp_ff    <= dtpc_pkg::MinDispReset;
      end else if (csr_valid && csr_ready) begin
         case (dtpc_pkg::csr_index_type'(csr_index))
            dtpc_pkg::CsrFocalX:    focal_x_ff     <= csr_data[15:0];
            dtpc_pkg::CsrInvFocalX: inv_focal_x_ff <= csr_data;
            dtpc_pkg::CsrInvFocalY: inv_focal_y_ff <= csr_data;
            dtpc_pkg::CsrCenterX:   center_x_ff    <= csr_data[15:0];
            dtpc_pkg::CsrCenterY:   center_y_ff    <= csr_data[15:0];
            dtpc_pkg::CsrBaseline:  baseline_ff    <= csr_data[23:0];
            dtpc_pkg::CsrMinDisp:   min_disp_ff    <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // Positive disparity above the threshold
   assign a_ok_in = !req_disparity[15] && (req_disparity[14:0] > min_disp_ff);

   always_comb begin
      b_data_in       = '0;
      b_data_in.ok    = p_ok_ff;
      b_data_in.disp  = p_disp_ff;
      // Quotient needs more than 32 bits when the top byte already holds the divisor
      b_data_in.sat   = dtpc_pkg::DispBits'(p_num_ff[dtpc_pkg::NumBits-1:32]) >= p_disp_ff;
      b_data_in.rem   = dtpc_pkg::DispBits'(p_num_ff[dtpc_pkg::NumBits-1:32]);
      b_data_in.qd    = p_num_ff[31:0];
      b_data_in.col   = p_col_ff;
      b_data_in.row   = p_row_ff;
      b_data_in.color = p_color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_full_ff <= 1'b0;
         p_full_ff <= 1'b0;
         b_full_ff <= 1'b0;
      end else begin
         a_full_ff <= accept;
         p_full_ff <= a_full_ff;
         b_full_ff <= p_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ok_ff    <= a_ok_in;
      a_disp_ff  <= req_disparity[14:0];
      a_col_ff   <= req_column;
      a_row_ff   <= req_row;
      a_color_ff <= {req_red, req_green, req_blue};
      p_ok_ff    <= a_ok_ff;
      p_disp_ff  <= a_disp_ff;
      p_num_ff   <= dtpc_pkg::NumBits'(baseline_ff * focal_x_ff);
      p_col_ff   <= a_col_ff;
      p_row_ff   <= a_row_ff;
      p_color_ff <= a_color_ff;
      b_data_ff  <= b_data_in;
   end

   assign chain_full[0] = b_full_ff;
   assign chain_data[0] = b_data_ff;

   for (genvar i = 0; i < Steps; i++) begin : g_cell
      dtpc_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_full  (chain_full[i]),
         .in_data  (chain_data[i]),
         .out_full (chain_full[i+1]),
         .out_data (chain_data[i+1])
      );
   end

   always_comb begin
      z_sat = chain_data[Steps].sat ? 32'hFFFF_FFFF : chain_data[Steps].qd;
      z_ok  = chain_data[Steps].ok && (z_sat != 32'd0);
      side_in.pvalid = z_ok;
      side_in.z      = z_sat;
      side_in.color  = chain_data[Steps].color;
   end

   dtpc_project u_project_x (
      .clock  (clock),
      .coord  (chain_data[Steps].col),
      .center (center_x_ff),
      .z      (z_sat),
      .inv    (inv_focal_x_ff),
      .result (proj_x)
   );

   dtpc_project u_project_y (
      .clock  (clock),
      .coord  (chain_data[Steps].row),
      .center (center_y_ff),
      .z      (z_sat),
      .inv    (inv_focal_y_ff),
      .result (proj_y)
   );

   // Carry depth and colour alongside the projection multipliers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < dtpc_pkg::ProjStages; s++) begin
            side_full_ff[s] <= 1'b0;
         end
      end else begin
         side_full_ff[0] <= chain_full[Steps];
         for (int s = 1; s < dtpc_pkg::ProjStages; s++) begin
            side_full_ff[s] <= side_full_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int s = 1; s < dtpc_pkg::ProjStages; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   assign side_last = side_ff[dtpc_pkg::ProjStages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= side_full_ff[dtpc_pkg::ProjStages-1];
      end
   end

   // Zero every field of a point that failed the disparity or depth test
   always_ff @(posedge clock) begin
      rsp_pvalid_ff <= side_last.pvalid;
      rsp_x_ff      <= side_last.pvalid ? proj_x : 32'sd0;
      rsp_y_ff      <= side_last.pvalid ? proj_y : 32'sd0;
      rsp_z_ff      <= side_last.pvalid ? side_last.z : 32'd0;
      rsp_color_ff  <= side_last.pvalid ? side_last.color : 24'd0;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_point_valid  = rsp_valid_ff && rsp_pvalid_ff;
   assign rsp_point_x      = rsp_x_ff;
   assign rsp_point_y      = rsp_y_ff;
   assign rsp_point_z      = rsp_z_ff;
   assign rsp_color_packed = rsp_color_ff;

   a_rsp_from_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, Steps + 8))
      else $error("result without a matching transfer");

   a_transfer_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##(Steps + 7) rsp_valid)
      else $error("transfer produced no result");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_point_valid) |-> (rsp_point_z == 32'd0 && rsp_point_x == 32'sd0
         && rsp_point_y == 32'sd0 && rsp_color_packed == 24'd0))
      else $error("invalid point carries non-zero fields");

   a_valid_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_point_valid |-> (rsp_point_z != 32'd0))
      else $error("valid point with zero depth");

endmodule
